// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion lbl failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("assertion lbl failed");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== hw/rtl/ssr_pkg.sv =====
package ssr_pkg;

    // sprite geometry
    localparam int ROWS     = 21;
    localparam int COLS     = 24;
    localparam int FATS     = 12;
    localparam int LAST_ROW = 20;
    localparam int ROW_AW   = 5;

    // angle folding points
    localparam int QUARTER_TURN = 90;
    localparam int HALF_TURN    = 180;
    localparam int THREE_QUARTER = 270;
    localparam int FULL_TURN    = 360;
    localparam int MAG_N        = 91;

    // fixed point widths: factors Q2.16, products, rounded offsets
    localparam int FW = 18;
    localparam int PW = 32;
    localparam int OW = 16;

    // cycles to wait after the last sample until lane counts settle
    localparam int PIPE_DRAIN = 12;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // register select on paddr[2]
    localparam logic REG_ANGLE = 1'b0;
    localparam logic REG_MODE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_MERGE
    } state_t;

    typedef struct packed {
        logic smp_valid;
        logic clr;
        logic flip;
        logic mc;
    } lane_ctl_t;

    // {sin e in Q16, tan e/2 in Q16} per degree of magnitude
    typedef logic [33:0] shear_rom_t [MAG_N];

    // bit-serial unsigned divide, elaboration only
    function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // taylor series in Q30, then the two factors per magnitude
    function automatic shear_rom_t build_rom();
        shear_rom_t rom;
        logic [63:0] x;
        logic [63:0] ts;
        logic [63:0] tc;
        logic [63:0] ss;
        logic [63:0] sc;
        logic [63:0] sn;
        logic [63:0] tn;
        for (int m = 0; m < MAG_N; m++) begin
            x  = udiv64(64'(m) * PI_Q30, 64'd360);
            ts = x;
            ss = x;
            tc = 64'd1 << 30;
            sc = 64'd1 << 30;
            for (int k = 1; k <= 6; k++) begin
                ts = (ts * x) >> 30;
                ts = (ts * x) >> 30;
                ts = udiv64(ts, 64'((2 * k) * (2 * k + 1)));
                tc = (tc * x) >> 30;
                tc = (tc * x) >> 30;
                tc = udiv64(tc, 64'((2 * k - 1) * (2 * k)));
                if ((k % 2) == 1) begin
                    ss = ss - ts;
                    sc = sc - tc;
                end else begin
                    ss = ss + ts;
                    sc = sc + tc;
                end
            end
            sn = (((64'd2 * ss * sc) >> 30) + 64'd8192) >> 14;
            tn = udiv64((ss << 17) + sc, 64'd2 * sc);
            rom[m] = {sn[16:0], tn[16:0]};
        end
        return rom;
    endfunction

    // Q16 product to integer, half away from zero
    function automatic logic signed [OW-1:0] round_q16(logic signed [PW-1:0] p);
        logic [PW-1:0] m;
        logic [PW-1:0] r;
        m = p[PW-1] ? PW'(-p) : PW'(p);
        r = (m + PW'(32768)) >> 16;
        return p[PW-1] ? -$signed(r[OW-1:0]) : $signed(r[OW-1:0]);
    endfunction

endpackage

// ===== hw/rtl/sprite_shear_rotation.sv =====
// after row 20 is taken, the output rows are made in turn: the sample counter walks
// each lane over its 2U x 2U block, the pipeline drains, and the merged word is loaded
// into the output register once that register is free, before the next row starts
// rows 0..20 are stored as they are accepted; no word is taken while a sprite rotates
// reset: synchronous, active low; clears control, the configuration registers, the lane
// counts and the output valid flag; sprite rows hold no defined value until written
`include "assert_macros.svh"

module sprite_shear_rotation #(
    parameter int UPSCALE = 4,
    parameter int BORDER  = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // row_bits[23:0], row_index[28:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // rotated_bits[23:0], out_row[28:24]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FIELD = (48 + 2 * BORDER) * UPSCALE;
    localparam int ORG   = BORDER * UPSCALE;
    localparam int CEN   = ORG + 24 * UPSCALE;
    localparam int CW    = $clog2(FIELD) + 3;
    localparam int DIV   = 2 * UPSCALE;
    localparam int UXW   = $clog2(DIV);
    localparam int NSMP  = 4 * UPSCALE * UPSCALE;
    localparam int CNTW  = $clog2(NSMP + 1);
    localparam int DW    = $clog2(ssr_pkg::PIPE_DRAIN);
    localparam int RW    = ssr_pkg::ROW_AW;
    localparam int FW    = ssr_pkg::FW;

    localparam ssr_pkg::shear_rom_t SHEAR_ROM = ssr_pkg::build_rom();

    ssr_pkg::state_t state_reg, state_next;

    logic [8:0]            angle_reg;
    logic                  mc_reg;
    logic [RW-1:0]         row_reg;
    logic [UXW-1:0]        ux_reg, uy_reg;
    logic [DW-1:0]         drain_reg;
    logic [ssr_pkg::COLS-1:0] out_bits_reg;
    logic [RW-1:0]         out_row_reg;
    logic                  m_valid_reg;
    logic [33:0]           rom_reg;
    logic                  flip_reg, neg_reg;
    logic                  smp_valid_reg;
    logic [UXW-1:0]        ux_s_reg;
    logic signed [CW-1:0]  y_s_reg;
    logic signed [ssr_pkg::PW-1:0] prod1_reg;

    logic [8:0]            ang;
    logic [6:0]            mag;
    logic                  neg, flip;
    logic signed [FW-1:0]  shx, shy;
    logic signed [CW-1:0]  y_issue;
    logic                  accept_in, start, out_free, out_load, clr, issue, last_smp;
    logic [RW-1:0]         in_idx;
    logic [ssr_pkg::COLS-1:0] merged;
    logic [ssr_pkg::COLS-1:0][3:0][CNTW-1:0] cnt_all;
    ssr_pkg::lane_ctl_t    ctl;

    assign in_idx    = s_tdata[28:24];
    assign accept_in = s_tvalid && s_tready;
    assign start     = accept_in && (in_idx == RW'(ssr_pkg::LAST_ROW));
    assign out_free  = !m_valid_reg || m_tready;
    assign last_smp  = (ux_reg == UXW'(DIV - 1)) && (uy_reg == UXW'(DIV - 1));

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg <= '0;
            mc_reg    <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                ssr_pkg::REG_ANGLE: angle_reg <= pwdata[8:0];
                ssr_pkg::REG_MODE:  mc_reg    <= pwdata[0];
                default:            angle_reg <= angle_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            ssr_pkg::REG_ANGLE: prdata = {23'd0, angle_reg};
            ssr_pkg::REG_MODE:  prdata = {31'd0, mc_reg};
            default:            prdata = '0;
        endcase
    end

    // fold the angle into a magnitude of at most a quarter turn
    always_comb begin
        ang  = (angle_reg >= 9'(ssr_pkg::FULL_TURN)) ? angle_reg - 9'(ssr_pkg::FULL_TURN)
                                                     : angle_reg;
        flip = (ang > 9'(ssr_pkg::QUARTER_TURN)) && (ang < 9'(ssr_pkg::THREE_QUARTER));
        if (ang <= 9'(ssr_pkg::QUARTER_TURN)) begin
            mag = ang[6:0];
            neg = 1'b0;
        end else if (ang < 9'(ssr_pkg::HALF_TURN)) begin
            mag = 7'(9'(ssr_pkg::HALF_TURN) - ang);
            neg = 1'b1;
        end else if (ang < 9'(ssr_pkg::THREE_QUARTER)) begin
            mag = 7'(ang - 9'(ssr_pkg::HALF_TURN));
            neg = 1'b0;
        end else begin
            mag = 7'(9'(ssr_pkg::FULL_TURN) - ang);
            neg = 1'b1;
        end
    end

    // registered factor lookup
    always_ff @(posedge aclk) begin
        rom_reg  <= SHEAR_ROM[mag];
        neg_reg  <= neg;
        flip_reg <= flip;
    end

    assign shx = neg_reg ? $signed({1'b0, rom_reg[16:0]}) : -$signed({1'b0, rom_reg[16:0]});
    assign shy = neg_reg ? -$signed({1'b0, rom_reg[33:17]}) : $signed({1'b0, rom_reg[33:17]});

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ssr_pkg::ST_IDLE:  if (start) state_next = ssr_pkg::ST_ISSUE;
            ssr_pkg::ST_ISSUE: if (last_smp) state_next = ssr_pkg::ST_DRAIN;
            ssr_pkg::ST_DRAIN: begin
                if (drain_reg == DW'(ssr_pkg::PIPE_DRAIN - 1)) state_next = ssr_pkg::ST_MERGE;
            end
            ssr_pkg::ST_MERGE: begin
                if (out_free) begin
                    state_next = (row_reg == RW'(ssr_pkg::LAST_ROW)) ? ssr_pkg::ST_IDLE
                                                                     : ssr_pkg::ST_ISSUE;
                end
            end
            default: state_next = ssr_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        clr      = 1'b0;
        unique case (state_reg)
            ssr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                clr      = start;
            end
            ssr_pkg::ST_ISSUE: issue = 1'b1;
            ssr_pkg::ST_DRAIN: issue = 1'b0;
            ssr_pkg::ST_MERGE: begin
                out_load = out_free;
                clr      = out_free && (row_reg != RW'(ssr_pkg::LAST_ROW));
            end
            default: issue = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ssr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // row, sample and drain counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            ux_reg    <= '0;
            uy_reg    <= '0;
            drain_reg <= '0;
        end else begin
            if (start) begin
                row_reg <= '0;
            end else if (out_load && (row_reg != RW'(ssr_pkg::LAST_ROW))) begin
                row_reg <= row_reg + RW'(1);
            end
            if (clr) begin
                ux_reg <= '0;
                uy_reg <= '0;
            end else if (issue) begin
                if (uy_reg == UXW'(DIV - 1)) begin
                    uy_reg <= '0;
                    ux_reg <= ux_reg + UXW'(1);
                end else begin
                    uy_reg <= uy_reg + UXW'(1);
                end
            end
            if (state_reg == ssr_pkg::ST_DRAIN) begin
                drain_reg <= drain_reg + DW'(1);
            end else begin
                drain_reg <= '0;
            end
        end
    end

    // shared first shear product, y is common to all lanes
    assign y_issue = CW'(ORG + 3 * UPSCALE) + CW'(row_reg) * CW'(DIV) + CW'(uy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smp_valid_reg <= 1'b0;
        end else begin
            smp_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        ux_s_reg  <= ux_reg;
        y_s_reg   <= y_issue;
        prod1_reg <= ssr_pkg::PW'(shx) * ssr_pkg::PW'(y_issue - CW'(CEN));
    end

    assign ctl = '{smp_valid: smp_valid_reg, clr: clr, flip: flip_reg, mc: mc_reg};

    // pixel lanes
    for (genvar g = 0; g < ssr_pkg::COLS; g++) begin : g_lane
        ssr_lane #(
            .UPSCALE (UPSCALE),
            .BORDER  (BORDER),
            .LANE    (g),
            .CW      (CW),
            .UXW     (UXW),
            .CNTW    (CNTW)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .ux      (ux_s_reg),
            .y       (y_s_reg),
            .prod1   (prod1_reg),
            .shx     (shx),
            .shy     (shy),
            .wr_en   (accept_in && (in_idx <= RW'(ssr_pkg::LAST_ROW))),
            .wr_addr (in_idx),
            .wr_data (s_tdata[23:0]),
            .cnt     (cnt_all[g])
        );
    end

    ssr_merge #(
        .UPSCALE (UPSCALE),
        .CNTW    (CNTW)
    ) u_merge (
        .cnt  (cnt_all),
        .mc   (mc_reg),
        .bits (merged)
    );

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_bits_reg <= merged;
            out_row_reg  <= row_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, out_row_reg, out_bits_reg};
    assign m_tlast  = out_row_reg == RW'(ssr_pkg::LAST_ROW);

    // checks
    `ASSERT_CLK(a_row_range, aclk, aresetn,
        (state_reg != ssr_pkg::ST_IDLE) |-> (row_reg <= RW'(ssr_pkg::LAST_ROW)))
    `ASSERT_CLK(a_smp_from_issue, aclk, aresetn,
        smp_valid_reg |-> ($past(state_reg) == ssr_pkg::ST_ISSUE))
    `ASSERT_NEVER(a_out_row_range, aclk, aresetn,
        m_valid_reg && (out_row_reg > RW'(ssr_pkg::LAST_ROW)))

endmodule

// ===== hw/rtl/ssr_lane.sv =====
module ssr_lane #(
    parameter int UPSCALE = 4,
    parameter int BORDER  = 48,
    parameter int LANE    = 0,
    parameter int CW      = 14,
    parameter int UXW     = 3,
    parameter int CNTW    = 7
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ssr_pkg::lane_ctl_t               ctl,
    input  logic [UXW-1:0]                   ux,
    input  logic signed [CW-1:0]             y,
    input  logic signed [ssr_pkg::PW-1:0]    prod1,
    input  logic signed [ssr_pkg::FW-1:0]    shx,
    input  logic signed [ssr_pkg::FW-1:0]    shy,
    input  logic                             wr_en,
    input  logic [ssr_pkg::ROW_AW-1:0]       wr_addr,
    input  logic [ssr_pkg::COLS-1:0]         wr_data,
    output logic [3:0][CNTW-1:0]             cnt
);

    localparam int FIELD = (48 + 2 * BORDER) * UPSCALE;
    localparam int ORG   = BORDER * UPSCALE;
    localparam int CEN   = ORG + 24 * UPSCALE;
    localparam int XB    = ORG + 2 * LANE * UPSCALE;
    localparam int YO    = ORG + 3 * UPSCALE;
    localparam int DIV   = 2 * UPSCALE;
    localparam int RECIP = (65536 + DIV - 1) / DIV;
    localparam int MW    = CW + 16;

    // sprite copy for this lane, one read port
    logic [ssr_pkg::COLS-1:0] mem [ssr_pkg::ROWS];

    logic                        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic                        ok1_reg, ok2_reg, ok3_reg, ok4_reg, ok5_reg, ok6_reg, ok7_reg;
    logic signed [CW-1:0]        x2_1_reg, x2_2_reg, x2_3_reg, x2_4_reg;
    logic signed [CW-1:0]        y_1_reg, y_2_reg, y2_3_reg, y2_4_reg;
    logic signed [ssr_pkg::PW-1:0] prod2_reg, prod3_reg;
    logic [CW-1:0]               rx_reg, ry_reg;
    logic [ssr_pkg::ROW_AW-1:0]  row6_reg, col6_reg, sel7_reg;
    logic [ssr_pkg::COLS-1:0]    word_reg;

    logic signed [CW-1:0]        x_s1, x2_next, y2_next, x1_next, rx_next, ry_next;
    logic                        ok5_next;
    logic [MW-1:0]               rowm, colm;
    logic [ssr_pkg::ROW_AW-1:0]  addr7, sel7_next, c_h, fp, f_m;
    logic [1:0]                  val;

    // first shear: x by the shared offset
    assign x_s1    = CW'(XB) + $signed(CW'(ux));
    assign x2_next = x_s1 - CW'(ssr_pkg::round_q16(prod1));

    // second shear result
    assign y2_next = y_2_reg - CW'(ssr_pkg::round_q16(prod2_reg));

    // third shear and position inside the sprite block
    assign x1_next = x2_4_reg - CW'(ssr_pkg::round_q16(prod3_reg));
    assign rx_next = x1_next - CW'(ORG);
    assign ry_next = y2_4_reg - CW'(YO);
    assign ok5_next = ok4_reg && !x1_next[CW-1] && ($unsigned(x1_next) < CW'(FIELD))
                   && !rx_next[CW-1] && ($unsigned(rx_next) < CW'(48 * UPSCALE))
                   && !ry_next[CW-1] && ($unsigned(ry_next) < CW'(42 * UPSCALE));

    // divide by the block size through a reciprocal
    assign rowm = MW'(ry_reg) * MW'(RECIP);
    assign colm = MW'(rx_reg) * MW'(RECIP);

    // flip mapping and bit select
    assign fp    = {1'b0, col6_reg[ssr_pkg::ROW_AW-1:1]};
    assign addr7 = ctl.flip ? ssr_pkg::ROW_AW'(ssr_pkg::LAST_ROW) - row6_reg : row6_reg;
    assign c_h   = ctl.flip ? ssr_pkg::ROW_AW'(ssr_pkg::COLS - 1) - col6_reg : col6_reg;
    assign f_m   = ctl.flip ? ssr_pkg::ROW_AW'(ssr_pkg::FATS - 1) - fp : fp;
    assign sel7_next = ctl.mc ? {f_m[ssr_pkg::ROW_AW-2:0], 1'b0} : c_h;

    always_comb begin
        if (!ok7_reg) begin
            val = 2'd0;
        end else if (ctl.mc) begin
            val = {word_reg[sel7_reg], word_reg[sel7_reg | ssr_pkg::ROW_AW'(1)]};
        end else begin
            val = {1'b0, word_reg[sel7_reg]};
        end
    end

    // valid pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            v1_reg <= ctl.smp_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // datapath pipe
    always_ff @(posedge aclk) begin
        x2_1_reg  <= x2_next;
        y_1_reg   <= y;
        ok1_reg   <= !x2_next[CW-1] && ($unsigned(x2_next) < CW'(FIELD));
        prod2_reg <= ssr_pkg::PW'(shy) * ssr_pkg::PW'(x2_1_reg - CW'(CEN));
        x2_2_reg  <= x2_1_reg;
        y_2_reg   <= y_1_reg;
        ok2_reg   <= ok1_reg;
        y2_3_reg  <= y2_next;
        x2_3_reg  <= x2_2_reg;
        ok3_reg   <= ok2_reg && !y2_next[CW-1] && ($unsigned(y2_next) < CW'(FIELD));
        prod3_reg <= ssr_pkg::PW'(shx) * ssr_pkg::PW'(y2_3_reg - CW'(CEN));
        x2_4_reg  <= x2_3_reg;
        y2_4_reg  <= y2_3_reg;
        ok4_reg   <= ok3_reg;
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
        ok5_reg   <= ok5_next;
        row6_reg  <= rowm[16 +: ssr_pkg::ROW_AW];
        col6_reg  <= colm[16 +: ssr_pkg::ROW_AW];
        ok6_reg   <= ok5_reg;
        sel7_reg  <= sel7_next;
        ok7_reg   <= ok6_reg;
    end

    // sprite memory, written by every accepted word with a row index up to 20
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        word_reg <= mem[addr7];
    end

    // per index sample counts
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr) begin
            cnt <= '0;
        end else if (v7_reg) begin
            cnt[val] <= cnt[val] + CNTW'(1);
        end
    end

endmodule

// ===== hw/rtl/ssr_merge.sv =====
module ssr_merge #(
    parameter int UPSCALE = 4,
    parameter int CNTW    = 7
) (
    input  logic [ssr_pkg::COLS-1:0][3:0][CNTW-1:0] cnt,
    input  logic                                    mc,
    output logic [ssr_pkg::COLS-1:0]                bits
);

    localparam int HALF = 2 * UPSCALE * UPSCALE;

    // hires threshold or fat pixel majority, lowest index on ties
    always_comb begin
        logic [CNTW:0] tot [4];
        logic [1:0]    best;
        bits = '0;
        for (int c = 0; c < 4; c++) begin
            tot[c] = '0;
        end
        best = 2'd0;
        if (!mc) begin
            for (int p = 0; p < ssr_pkg::COLS; p++) begin
                bits[p] = cnt[p][1] >= CNTW'(HALF);
            end
        end else begin
            for (int q = 0; q < ssr_pkg::FATS; q++) begin
                for (int c = 0; c < 4; c++) begin
                    tot[c] = {1'b0, cnt[2*q][c]} + {1'b0, cnt[2*q+1][c]};
                end
                best = 2'd0;
                for (int c = 1; c < 4; c++) begin
                    if (tot[c] > tot[best]) begin
                        best = 2'(c);
                    end
                end
                bits[2*q]   = best[1];
                bits[2*q+1] = best[0];
            end
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
module tb;

    // geometry of the sample field at the default parameters
    localparam int UPS      = 4;
    localparam int BRD      = 48;
    localparam int FIELD_SZ = (48 + 2 * BRD) * UPS;
    localparam int ORIGIN   = BRD * UPS;
    localparam int CENTRE   = ORIGIN + 24 * UPS;
    localparam int SETTLE   = 4 * UPS * UPS + 40;

    // register byte addresses
    localparam logic [2:0] ADDR_ANGLE = 3'd0;
    localparam logic [2:0] ADDR_MODE  = 3'd4;

    typedef struct {
        logic [23:0] bits;
        logic [4:0]  row;
        logic        last;
    } rot_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sprite_shear_rotation u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [23:0]        sprite_rows [21];
    int                 shx_tab [360];
    int                 shy_tab [360];
    logic [8:0]         cur_angle;
    logic               cur_mc;
    rot_row_t           rows_due [$];
    logic [31:0]        pending_words [$];
    int                 errors;
    int                 rotations;
    int                 rows_seen;

    always begin
        aclk = 1'b1; #1;
        aclk = 1'b0; #1;
    end

    // per-degree shear factors from truncated taylor series in Q30
    function automatic void build_shears();
        longint unsigned x, ts, tc, ss, sc, sn, tn, mag;
        int e;
        for (int a = 0; a < 360; a++) begin
            e = a <= 90 ? a : (a < 270 ? a - 180 : a - 360);
            mag = e < 0 ? -e : e;
            x = mag * 64'd3373259426 / 64'd360;
            ts = x; ss = x; tc = 64'd1 << 30; sc = 64'd1 << 30;
            for (int k = 1; k <= 6; k++) begin
                ts = (ts * x) >> 30; ts = (ts * x) >> 30;
                ts = ts / ((2 * k) * (2 * k + 1));
                tc = (tc * x) >> 30; tc = (tc * x) >> 30;
                tc = tc / ((2 * k - 1) * (2 * k));
                if (k % 2 == 1) begin
                    ss = ss - ts; sc = sc - tc;
                end else begin
                    ss = ss + ts; sc = sc + tc;
                end
            end
            sn = (((64'd2 * ss * sc) >> 30) + 64'd8192) >> 14;
            tn = ((ss << 17) + sc) / (64'd2 * sc);
            shx_tab[a] = e < 0 ? int'(tn) : -int'(tn);
            shy_tab[a] = e < 0 ? -int'(sn) : int'(sn);
        end
    endfunction

    // factor times distance, rounded half away from zero
    function automatic longint offset_of(int f, longint d);
        longint p, r;
        p = longint'(f) * d;
        r = ((p < 0 ? -p : p) + 32768) >>> 16;
        return p < 0 ? -r : r;
    endfunction

    function automatic int sprite_pix(longint row, longint col);
        if (row < 0 || row >= 21 || col < 0 || col >= 24) return 0;
        return int'(sprite_rows[row][col]);
    endfunction

    // value of one sample of the rotated field, by inverse mapping
    function automatic int field_sample(longint x, longint y, int shx, int shy,
                                        bit flip, bit mc);
        longint x2, y2, x1, rx, ry, row, col;
        x2 = x - offset_of(shx, y - CENTRE);
        if (x2 < 0 || x2 >= FIELD_SZ) return 0;
        y2 = y - offset_of(shy, x2 - CENTRE);
        if (y2 < 0 || y2 >= FIELD_SZ) return 0;
        x1 = x2 - offset_of(shx, y2 - CENTRE);
        if (x1 < 0 || x1 >= FIELD_SZ) return 0;
        rx = x1 - ORIGIN;
        ry = y2 - ORIGIN - 3 * UPS;
        if (rx < 0 || rx >= 48 * UPS || ry < 0 || ry >= 42 * UPS) return 0;
        row = ry / (2 * UPS);
        if (!mc) begin
            col = rx / (2 * UPS);
            return flip ? sprite_pix(20 - row, 23 - col) : sprite_pix(row, col);
        end
        col = rx / (4 * UPS);
        if (flip)
            return sprite_pix(20 - row, 22 - 2 * col) * 2 + sprite_pix(20 - row, 23 - 2 * col);
        return sprite_pix(row, 2 * col) * 2 + sprite_pix(row, 2 * col + 1);
    endfunction

    // votes all 21 output rows of the current sprite
    function automatic void rotate_sprite();
        int a, shx, shy, cnt, best;
        int votes [4];
        bit flip;
        longint yb;
        rot_row_t r;
        a = cur_angle >= 360 ? cur_angle - 360 : cur_angle;
        flip = a > 90 && a < 270;
        shx = shx_tab[a];
        shy = shy_tab[a];
        for (int row = 0; row < 21; row++) begin
            yb = ORIGIN + (2 * row + 3) * UPS;
            r.bits = '0;
            r.row = 5'(row);
            r.last = row == ssr_pkg::LAST_ROW;
            if (!cur_mc) begin
                for (int p = 0; p < 24; p++) begin
                    cnt = 0;
                    for (int ux = 0; ux < 2 * UPS; ux++)
                        for (int uy = 0; uy < 2 * UPS; uy++)
                            cnt += field_sample(ORIGIN + 2 * p * UPS + ux, yb + uy,
                                                shx, shy, flip, 1'b0);
                    r.bits[p] = cnt >= 2 * UPS * UPS;
                end
            end else begin
                for (int p = 0; p < 12; p++) begin
                    votes = '{0, 0, 0, 0};
                    for (int ux = 0; ux < 4 * UPS; ux++)
                        for (int uy = 0; uy < 2 * UPS; uy++)
                            votes[field_sample(ORIGIN + 4 * p * UPS + ux, yb + uy,
                                               shx, shy, flip, 1'b1)]++;
                    best = 0;
                    for (int c = 1; c < 4; c++)
                        if (votes[c] > votes[best]) best = c;
                    r.bits[2 * p]     = best[1];
                    r.bits[2 * p + 1] = best[0];
                end
            end
            rows_due.push_back(r);
        end
    endfunction

    // sender: bursts of words with random gaps, prediction on acceptance
    int burst_left;
    int gap_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_tvalid && s_tready && s_tdata[28:24] <= ssr_pkg::LAST_ROW) begin
                sprite_rows[s_tdata[28:24]] = s_tdata[23:0];
                if (s_tdata[28:24] == ssr_pkg::LAST_ROW) begin
                    rotate_sprite();
                    rotations++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    s_tdata  <= pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern: runs of ready and stall, sometimes long ready runs
    int stall_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            m_tready   <= !m_tready;
            stall_left <= (!m_tready && $urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                                    : $urandom_range(0, 30);
        end
    end

    // checker: each word against the oldest predicted row
    rot_row_t want;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            rows_seen++;
            if (rows_due.size() == 0) begin
                $error("unexpected word %h", m_tdata);
                errors++;
            end else begin
                want = rows_due.pop_front();
                if (m_tdata[23:0] !== want.bits) begin
                    $error("rotated_bits expected %h actual %h", want.bits, m_tdata[23:0]);
                    errors++;
                end
                if (m_tdata[28:24] !== want.row) begin
                    $error("out_row expected %0d actual %0d", want.row, m_tdata[28:24]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_row expected %0d actual %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_ANGLE) cur_angle = val[8:0];
        else cur_mc = val[0];
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || s_tvalid || rows_due.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [23:0] random_row();
        logic [23:0] a, b;
        a = 24'($urandom);
        b = 24'($urandom);
        case ($urandom_range(0, 3))
            0: return a & b;
            1: return a | b;
            default: return a;
        endcase
    endfunction

    function automatic void queue_row(logic [4:0] idx, logic [23:0] bits);
        pending_words.push_back({3'b000, idx, bits});
    endfunction

    // full sprite in order, with stray words mixed in now and then
    function automatic void queue_sprite(bit noisy);
        for (int r = 0; r < 21; r++) begin
            if (noisy && $urandom_range(0, 19) == 0)
                queue_row(5'($urandom_range(21, 31)), 24'($urandom));
            queue_row(5'(r), random_row());
        end
    endfunction

    int angles [10] = '{0, 0, 90, 91, 180, 269, 270, 359, 45, 315};
    int modes  [10] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1};

    initial begin
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        errors = 0; rotations = 0; rows_seen = 0;
        cur_angle = '0; cur_mc = 1'b0;
        for (int r = 0; r < 21; r++) sprite_rows[r] = '0;
        build_shears();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed sprite: extreme rows, single pixels, checkerboards, stray indexes
        reg_write(ADDR_ANGLE, 0);
        reg_write(ADDR_MODE, 0);
        queue_row(5'd31, 24'hFFFFFF);
        queue_row(5'd21, 24'h000000);
        queue_row(5'd0, 24'hFFFFFF);
        queue_row(5'd1, 24'h000000);
        queue_row(5'd2, 24'h000001);
        queue_row(5'd3, 24'h800000);
        queue_row(5'd4, 24'hAAAAAA);
        queue_row(5'd5, 24'h555555);
        for (int r = 6; r < 20; r++) queue_row(5'(r), random_row());
        queue_row(5'd20, 24'hFFFFFF);
        wait_idle();

        // one phase per setting: angle extremes, fold points, both modes
        for (int ph = 0; ph < 11; ph++) begin
            if (ph < 10) begin
                reg_write(ADDR_ANGLE, angles[ph]);
                reg_write(ADDR_MODE, modes[ph]);
            end else begin
                reg_write(ADDR_ANGLE, $urandom_range(0, 359));
                reg_write(ADDR_MODE, $urandom_range(0, 1));
            end
            queue_sprite(1'b1);
            // a broken sequence: a few rewritten rows, then the closing row
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4))
                    queue_row(5'($urandom_range(0, 19)), random_row());
                queue_row(5'd20, random_row());
            end
            wait_idle();
        end

        $display("tb: %0d sprites rotated, %0d rows checked over hires and multicolor",
                 rotations, rows_seen);
        $display("tb: angles 0, 45, 90, 91, 180, 269, 270, 315, 359 and a random one");
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb: FAIL");
        $finish;
    end
endmodule
